### src/reinhard_gamma_tone_map_defines.svh
// Assertion macros shared by the tone mapper checker
`ifndef REINHARD_GAMMA_TONE_MAP_DEFINES_SVH
`define REINHARD_GAMMA_TONE_MAP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RGTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset too
`define RGTM_ASSERT_NXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rgtm_pkg.sv
// Types, constants and constant functions of the tone mapper
`timescale 1ns / 1ps
package rgtm_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int GAIN_W      = 16;
  localparam int NUM_W       = 24;
  localparam int DEN_W       = 24;
  localparam int GAMMA_FRAC  = 12;
  localparam int ACC_W       = 31;
  localparam int ACC_FRAC    = 30;
  localparam int SHIFT_W     = 5;
  localparam int MAX_SHIFT   = 31;
  localparam logic [DEN_W-1:0]    DEN_BIAS      = 24'd65280;
  localparam logic [GAIN_W-1:0]   EXPOSURE_RST  = 16'd384;
  localparam logic [GAIN_W-1:0]   INV_GAMMA_RST = 16'd1862;
  localparam logic [SAMPLE_W-1:0] TONE_MAX      = 8'd255;

  typedef enum logic {
    REG_EXPOSURE  = 1'b0,
    REG_INV_GAMMA = 1'b1
  } rgtm_reg_t;

  // Sideband that travels with every pipeline stage
  typedef struct packed {
    logic vld;
    logic last;
    logic zero;
    logic full;
  } rgtm_side_t;

  // Integer square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_v;
    v     = x;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (v >= res + bit_v) begin
        v   = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-k) in Q30: k-fold square root of one half
  function automatic logic [ACC_W-1:0] root_half(input int k);
    logic [63:0] r;
    r = 64'd1 << 29;
    for (int j = 0; j < k; j++) begin
      r = isqrt64(r << 30);
    end
    return r[ACC_W-1:0];
  endfunction

endpackage

### src/rgtm_div.sv
// Pipelined restoring divider forming y = n / (65280 + n) in Q0.F
`timescale 1ns / 1ps
module rgtm_div
  import rgtm_pkg::*;
#(
  parameter int F = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [NUM_W-1:0] num_i,
  input  rgtm_side_t       side_i,
  output logic [F-1:0]     quo_o,
  output rgtm_side_t       side_o
);

  logic [DEN_W-1:0] rem_r  [F];
  logic [DEN_W-1:0] den_r  [F];
  logic [F-1:0]     quo_r  [F];
  rgtm_side_t       side_r [F];

  for (genvar i = 0; i < F; i++) begin : g_step
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [F-1:0]     quo_in;
    rgtm_side_t       side_in;
    logic [DEN_W:0]   shl;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in  = DEN_W'(num_i);
      assign den_in  = DEN_W'(num_i) + DEN_BIAS;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign den_in  = den_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign side_in = side_r[i-1];
    end

    // Shift in one dividend bit and try the subtract
    assign shl = {rem_in, 1'b0};
    assign ge  = (shl >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[i] <= '0;
      end else begin
        side_r[i] <= side_in;
      end
      rem_r[i] <= ge ? DEN_W'(shl - {1'b0, den_in}) : DEN_W'(shl);
      den_r[i] <= den_in;
      quo_r[i] <= {quo_in[F-2:0], ge};
    end
  end

  assign quo_o  = quo_r[F-1];
  assign side_o = side_r[F-1];

endmodule

### src/rgtm_log.sv
// Pipelined log2: normalize, then one squaring per fraction bit
`timescale 1ns / 1ps
module rgtm_log
  import rgtm_pkg::*;
#(
  parameter int F = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [F-1:0]                  yq_i,
  input  rgtm_side_t                    side_i,
  output logic [F+$clog2(F+1)-1:0]      lq_o,
  output rgtm_side_t                    side_o
);

  localparam int IW = $clog2(F + 1);
  localparam int LW = F + IW;

  // Normalize stage
  logic [IW-1:0] sh_nxt;
  logic [F:0]    m_nxt;
  rgtm_side_t    nside_nxt;
  logic [IW-1:0] sh_r;
  logic [F:0]    m_r;
  rgtm_side_t    nside_r;

  always_comb begin
    sh_nxt = '0;
    for (int b = 0; b < F; b++) begin
      if (yq_i[b]) begin
        sh_nxt = IW'(F - b);
      end
    end
    m_nxt = (F+1)'(yq_i) << sh_nxt;
  end

  // Flag a quotient of zero
  always_comb begin
    nside_nxt      = side_i;
    nside_nxt.zero = side_i.zero | (yq_i == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nside_r <= '0;
    end else begin
      nside_r <= nside_nxt;
    end
    sh_r <= sh_nxt;
    m_r  <= m_nxt;
  end

  // Squaring stages, one fraction bit each
  logic [F:0]    sq_m_r    [F];
  logic [F-1:0]  sq_frac_r [F];
  logic [IW-1:0] sq_sh_r   [F];
  rgtm_side_t    sq_side_r [F];

  for (genvar i = 0; i < F; i++) begin : g_sq
    logic [F:0]       m_in;
    logic [F-1:0]     frac_in;
    logic [IW-1:0]    sh_in;
    rgtm_side_t       side_in;
    logic [2*F+1:0]   prod;
    logic [F+1:0]     sqr;

    if (i == 0) begin : g_first
      assign m_in    = m_r;
      assign frac_in = '0;
      assign sh_in   = sh_r;
      assign side_in = nside_r;
    end else begin : g_next
      assign m_in    = sq_m_r[i-1];
      assign frac_in = sq_frac_r[i-1];
      assign sh_in   = sq_sh_r[i-1];
      assign side_in = sq_side_r[i-1];
    end

    assign prod = m_in * m_in;
    assign sqr  = prod[2*F+1:F];

    // Halve and emit a one when the square reaches two
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_side_r[i] <= '0;
      end else begin
        sq_side_r[i] <= side_in;
      end
      sq_m_r[i]    <= sqr[F+1] ? sqr[F+1:1] : sqr[F:0];
      sq_frac_r[i] <= {frac_in[F-2:0], sqr[F+1]};
      sq_sh_r[i]   <= sh_in;
    end
  end

  // -log2(y) in QF
  assign lq_o   = {sq_sh_r[F-1], {F{1'b0}}} - LW'(sq_frac_r[F-1]);
  assign side_o = sq_side_r[F-1];

endmodule

### src/rgtm_exp.sv
// Gamma scaling, pipelined exp2 over fraction bits, and output byte
`timescale 1ns / 1ps
module rgtm_exp
  import rgtm_pkg::*;
#(
  parameter int F = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [GAIN_W-1:0]        inv_gamma_i,
  input  logic [F+$clog2(F+1)-1:0] lq_i,
  input  rgtm_side_t               side_i,
  output logic                     strobe_o,
  output logic [SAMPLE_W-1:0]      tone_o,
  output logic                     last_o
);

  localparam int LW = F + $clog2(F + 1);
  localparam int PW = GAIN_W + LW;
  localparam int ZW = PW - GAMMA_FRAC;
  localparam int IPW = ZW - F;

  // Exponent z = inverse_gamma * L
  logic [PW-1:0]      zprod;
  logic [IPW-1:0]     ip;
  rgtm_side_t         zside_nxt;
  logic [SHIFT_W-1:0] ip_r;
  logic [F-1:0]       f_r;
  rgtm_side_t         zside_r;

  assign zprod = inv_gamma_i * lq_i;
  assign ip    = zprod[PW-1:GAMMA_FRAC+F];

  // Flag an exponent too large for the shifter
  always_comb begin
    zside_nxt      = side_i;
    zside_nxt.zero = side_i.zero | (ip >= IPW'(MAX_SHIFT));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zside_r <= '0;
    end else begin
      zside_r <= zside_nxt;
    end
    ip_r <= ip[SHIFT_W-1:0];
    f_r  <= zprod[GAMMA_FRAC+F-1:GAMMA_FRAC];
  end

  // Product of 2^(-2^-k) over the set fraction bits
  logic [ACC_W-1:0]   acc_r  [F];
  logic [F-1:0]       ef_r   [F];
  logic [SHIFT_W-1:0] eip_r  [F];
  rgtm_side_t         eside_r[F];

  for (genvar k = 0; k < F; k++) begin : g_exp
    localparam logic [ACC_W-1:0] ROOT = root_half(k + 1);
    logic [ACC_W-1:0]   acc_in;
    logic [F-1:0]       f_in;
    logic [SHIFT_W-1:0] ip_in;
    rgtm_side_t         side_in;
    logic [2*ACC_W-1:0] prod;

    if (k == 0) begin : g_first
      assign acc_in  = ACC_W'(1) << ACC_FRAC;
      assign f_in    = f_r;
      assign ip_in   = ip_r;
      assign side_in = zside_r;
    end else begin : g_next
      assign acc_in  = acc_r[k-1];
      assign f_in    = ef_r[k-1];
      assign ip_in   = eip_r[k-1];
      assign side_in = eside_r[k-1];
    end

    assign prod = acc_in * ROOT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        eside_r[k] <= '0;
      end else begin
        eside_r[k] <= side_in;
      end
      acc_r[k] <= f_in[F-1-k] ? prod[ACC_FRAC+ACC_W-1:ACC_FRAC] : acc_in;
      ef_r[k]  <= f_in;
      eip_r[k] <= ip_in;
    end
  end

  // Apply integer part, scale to a byte, resolve special cases
  logic [ACC_W-1:0]       v;
  logic [ACC_W+7:0]       scaled;
  logic [ACC_W+7-ACC_FRAC:0] res;
  logic [SAMPLE_W-1:0]    tone_nxt;
  logic                   strobe_r;
  logic [SAMPLE_W-1:0]    tone_r;
  logic                   last_r;

  assign v      = acc_r[F-1] >> eip_r[F-1];
  assign scaled = (ACC_W+8)'(v) * (ACC_W+8)'(TONE_MAX);
  assign res    = scaled[ACC_W+7:ACC_FRAC];

  always_comb begin
    if (eside_r[F-1].full) begin
      tone_nxt = TONE_MAX;
    end else if (eside_r[F-1].zero) begin
      tone_nxt = '0;
    end else if (res > (ACC_W+8-ACC_FRAC)'(TONE_MAX)) begin
      tone_nxt = TONE_MAX;
    end else begin
      tone_nxt = res[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= eside_r[F-1].vld;
    end
    tone_r <= tone_nxt;
    last_r <= eside_r[F-1].last;
  end

  assign strobe_o = strobe_r;
  assign tone_o   = tone_r;
  assign last_o   = last_r;

endmodule

### src/reinhard_gamma_tone_map.sv
// Reinhard tone mapper with gamma: one 8-bit channel sample in, one byte out
// Usage:
//   Input: drive in_sample_in and in_last_in with start high; a sample is
//   transferred at each clock edge with start high and busy low. busy is low
//   whenever reset is released, so one sample can be taken every cycle.
//   Output: out_strobe is high for exactly one cycle per sample, with
//   out_tone_out and out_last_out, in input order. The receiver cannot stall.
//   Pipeline: entry stage, then the divider, the squaring log2 and the exp2
//   chain, each one stage per fraction bit. Throughput: one sample per cycle.
//   Configuration: APB write of exposure_gain at address 0 and inverse_gamma
//   at address 4, while no samples are in flight; reads return the values.
//   Reset (rst_n low, synchronous) drops all samples in flight and restores
//   exposure 1.5 and inverse gamma 1862 (about 1/2.2).
`timescale 1ns / 1ps
module reinhard_gamma_tone_map
  import rgtm_pkg::*;
#(
  parameter int INTERNAL_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [SAMPLE_W-1:0] in_sample_in,
  input  logic                in_last_in,
  output logic                out_strobe,
  output logic [SAMPLE_W-1:0] out_tone_out,
  output logic                out_last_out,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int F  = INTERNAL_FRAC_BITS;
  localparam int LW = F + $clog2(F + 1);
  localparam int LATENCY = 3 * F + 4;

  // Configuration registers
  logic [GAIN_W-1:0] exposure_r;
  logic [GAIN_W-1:0] inv_gamma_r;
  rgtm_reg_t         reg_sel;
  logic              cfg_wr;

  assign reg_sel = rgtm_reg_t'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exposure_r  <= EXPOSURE_RST;
      inv_gamma_r <= INV_GAMMA_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_EXPOSURE:  exposure_r  <= pwdata[GAIN_W-1:0];
        REG_INV_GAMMA: inv_gamma_r <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_EXPOSURE:  prdata = 32'(exposure_r);
      REG_INV_GAMMA: prdata = 32'(inv_gamma_r);
      default:       prdata = '0;
    endcase
  end

  // Entry stage: n = sample * exposure
  logic              accept;
  logic [NUM_W-1:0]  num_r;
  rgtm_side_t        side_r;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else begin
      side_r.vld  <= accept;
      side_r.last <= in_last_in;
      side_r.zero <= (in_sample_in == '0) | (exposure_r == '0);
      side_r.full <= (inv_gamma_r == '0);
    end
    num_r <= in_sample_in * exposure_r;
  end

  logic [F-1:0]  yq;
  rgtm_side_t    div_side;
  logic [LW-1:0] lq;
  rgtm_side_t    log_side;

  rgtm_div #(.F(F)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .num_i  (num_r),
    .side_i (side_r),
    .quo_o  (yq),
    .side_o (div_side)
  );

  rgtm_log #(.F(F)) u_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .yq_i   (yq),
    .side_i (div_side),
    .lq_o   (lq),
    .side_o (log_side)
  );

  rgtm_exp #(.F(F)) u_exp (
    .clk         (clk),
    .rst_n       (rst_n),
    .inv_gamma_i (inv_gamma_r),
    .lq_i        (lq),
    .side_i      (log_side),
    .strobe_o    (out_strobe),
    .tone_o      (out_tone_out),
    .last_o      (out_last_out)
  );

endmodule

### src/rgtm_checker.sv
// Port-level checks of the tone mapper and their bind
`timescale 1ns / 1ps
`include "reinhard_gamma_tone_map_defines.svh"
module rgtm_checker #(
  parameter int LAT = 52
) (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last_in,
  input logic out_strobe,
  input logic out_last_out
);

  // Every transfer gives exactly one strobe after the fixed latency
  `RGTM_ASSERT_IMP(a_in_to_out, clk, rst_n, start && !busy, ##LAT out_strobe, "lost result")
  `RGTM_ASSERT_IMP(a_out_from_in, clk, rst_n, out_strobe, $past(start && !busy, LAT), "extra result")
  // Frame marker follows its sample
  `RGTM_ASSERT_IMP(a_last_match, clk, rst_n, out_strobe, out_last_out == $past(in_last_in, LAT), "last mismatch")
  // Reset drops everything in flight
  `RGTM_ASSERT_NXT(a_reset_quiet, clk, !rst_n, !out_strobe, "strobe after reset")

endmodule

bind reinhard_gamma_tone_map rgtm_checker #(.LAT(LATENCY)) u_rgtm_checker (.*);
